[rtl/wmcp_pkg.sv]
// ----------------------------------------------------------------------------
// wmcp_pkg
// Shared widths, types and constants of the windowed min-cost path block.
// ----------------------------------------------------------------------------
`default_nettype none

package wmcp_pkg;

   localparam int HEIGHT_W = 16;
   localparam int COST_W   = 32;
   localparam int JUMP_W   = 5;
   // candidate = cost + height difference, one carry bit wider than a cost
   localparam int CAND_W   = COST_W + 1;

   typedef logic [HEIGHT_W-1:0] height_type;
   typedef logic [COST_W-1:0]   cost_type;
   typedef logic [JUMP_W-1:0]   jump_type;
   typedef logic [CAND_W-1:0]   cand_type;

   // masked-off candidate: larger than any real sum
   localparam cand_type CAND_NONE = {CAND_W{1'b1}};
   localparam cost_type COST_MAX  = {COST_W{1'b1}};

endpackage

`default_nettype wire

[rtl/wmcp_cell.sv]
// ----------------------------------------------------------------------------
// wmcp_cell
// One window slot: holds a height and a cost, passes them to the next slot
// on a push, and registers its candidate cost for the current height.
// ----------------------------------------------------------------------------
`default_nettype none

module wmcp_cell (
   input  wire                  clock,
   input  wire                  shift_en,
   input  wire                  enable,
   input  wmcp_pkg::height_type cur_height,
   input  wmcp_pkg::height_type prev_height,
   input  wmcp_pkg::cost_type   prev_cost,
   output wmcp_pkg::height_type height_q,
   output wmcp_pkg::cost_type   cost_q,
   output wmcp_pkg::cand_type   cand_q
);
   import wmcp_pkg::*;

   height_type height_ff;
   cost_type   cost_ff;
   cand_type   cand_ff;
   cand_type   cand_in;
   height_type diff;

   // absolute height difference plus stored cost, or CAND_NONE when disabled
   always_comb begin
      if (cur_height >= height_ff) begin
         diff = cur_height - height_ff;
      end else begin
         diff = height_ff - cur_height;
      end
      if (enable) begin
         cand_in = {1'b0, cost_ff} + CAND_W'(diff);
      end else begin
         cand_in = CAND_NONE;
      end
   end

   // slot contents move one place down the chain on a push
   always_ff @(posedge clock) begin
      if (shift_en) begin
         height_ff <= prev_height;
         cost_ff   <= prev_cost;
      end
      cand_ff <= cand_in;
   end

   assign height_q = height_ff;
   assign cost_q   = cost_ff;
   assign cand_q   = cand_ff;

endmodule

`default_nettype wire

[rtl/wmcp_min_tree.sv]
// ----------------------------------------------------------------------------
// wmcp_min_tree
// Registered binary minimum tree, one register level per tree level.
// Leaves are already registered by the cells.
// ----------------------------------------------------------------------------
`default_nettype none

module wmcp_min_tree #(
   parameter int LEAVES = 16
) (
   input  wire                clock,
   input  wmcp_pkg::cand_type leaf [LEAVES],
   output wmcp_pkg::cand_type root
);
   import wmcp_pkg::*;

   generate
      if (LEAVES == 1) begin : g_single
         assign root = leaf[0];
      end else begin : g_tree
         localparam int NODES = LEAVES - 1;
         cand_type node_ff [NODES];

         // heap layout: node n has children 2n+1 and 2n+2, leaves follow the nodes
         for (genvar n = 0; n < NODES; n++) begin : g_node
            cand_type lhs;
            cand_type rhs;
            if (2*n + 1 < NODES) begin : g_lhs_node
               assign lhs = node_ff[2*n + 1];
            end else begin : g_lhs_leaf
               assign lhs = leaf[2*n + 1 - NODES];
            end
            if (2*n + 2 < NODES) begin : g_rhs_node
               assign rhs = node_ff[2*n + 2];
            end else begin : g_rhs_leaf
               assign rhs = leaf[2*n + 2 - NODES];
            end
            always_ff @(posedge clock) begin
               node_ff[n] <= (lhs < rhs) ? lhs : rhs;
            end
         end

         assign root = node_ff[0];
      end
   endgenerate

endmodule

`default_nettype wire

[rtl/windowed_min_cost_path_dp_top.sv]
// ----------------------------------------------------------------------------
// windowed_min_cost_path_dp_top
// Streaming minimum-cost path with bounded jumps over a window of the most
// recent MAX_JUMP heights and costs.
// ----------------------------------------------------------------------------
//
//   channel | direction | ports                              | transfer
//   --------+-----------+------------------------------------+-------------------
//   req     | in        | req_height, req_start_req          | req_valid & ready
//   rsp     | out       | rsp_cost, rsp_saturated            | rsp_valid & ready
//   csr     | in        | csr_jump_limit                     | csr_valid & ready
//
// An item is loaded into the request registers, its candidates are registered
// in the cells, and it then passes one register level per level of the min
// tree. A new item is taken only once the last one has finished, set by the
// dependence of each cost on the one before. A finished item waits while the
// result register is full. Reset is synchronous; the window needs no clearing
// pass (fill count only).
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_min_cost_path_dp_top #(
   parameter int MAX_JUMP = 16
) (
   input  wire                  clock,
   input  wire                  reset,
   // request channel
   input  wire                  req_valid,
   output logic                 req_ready,
   input  wmcp_pkg::height_type req_height,
   input  wire                  req_start_req,
   // result channel
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output wmcp_pkg::cost_type   rsp_cost,
   output logic                 rsp_saturated,
   // configuration channel
   input  wire                  csr_valid,
   output logic                 csr_ready,
   input  wmcp_pkg::jump_type   csr_jump_limit
);
   import wmcp_pkg::*;

   localparam int TREE_LVL = $clog2(MAX_JUMP);
   localparam int LEAVES   = 2 ** TREE_LVL;
   localparam int SEEN_W   = $clog2(MAX_JUMP + 1);
   localparam int CMP_W    = (SEEN_W > JUMP_W) ? SEEN_W : JUMP_W;
   localparam int CNT_W    = $clog2(TREE_LVL + 2) + 1;
   localparam logic [CNT_W-1:0] CNT_DONE = CNT_W'(TREE_LVL + 1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_CALC = 2'b10
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [SEEN_W-1:0] seen_ff, seen_in;
   jump_type          jump_limit_ff;
   height_type        height_ff;
   logic              start_ff;
   logic              rsp_valid_ff;
   cost_type          rsp_cost_ff;
   logic              rsp_sat_ff;

   logic              req_xfer;
   logic              finish;
   logic              start_eff;
   cost_type          new_cost;
   logic              new_sat;
   logic [CMP_W-1:0]  lim_eff;
   logic [CMP_W-1:0]  seen_ext;
   cand_type          root;

   height_type win_height [MAX_JUMP];
   cost_type   win_cost   [MAX_JUMP];
   cand_type   leaf       [LEAVES];

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // result is taken from the tree once it has settled and the output is free
   assign finish    = (state_ff == ST_CALC) && (cnt_ff == CNT_DONE) &&
                      (!rsp_valid_ff || rsp_ready);
   assign start_eff = start_ff || (seen_ff == '0);

   always_comb begin
      if (start_eff) begin
         new_cost = '0;
         new_sat  = 1'b0;
      end else if (root[CAND_W-1]) begin
         new_cost = COST_MAX;
         new_sat  = 1'b1;
      end else begin
         new_cost = root[COST_W-1:0];
         new_sat  = 1'b0;
      end
   end

   // effective jump limit: zero means one, clamp at window depth
   always_comb begin
      lim_eff = CMP_W'(jump_limit_ff);
      if (lim_eff == '0) begin
         lim_eff = CMP_W'(1);
      end else if (lim_eff > CMP_W'(MAX_JUMP)) begin
         lim_eff = CMP_W'(MAX_JUMP);
      end
      seen_ext = CMP_W'(seen_ff);
   end

   // cell chain: slot 0 takes the new entry, slot j takes slot j-1
   generate
      for (genvar j = 0; j < MAX_JUMP; j++) begin : g_cell
         height_type prev_h;
         cost_type   prev_c;
         logic       cell_en;
         if (j == 0) begin : g_head
            assign prev_h = height_ff;
            assign prev_c = new_cost;
         end else begin : g_link
            assign prev_h = win_height[j-1];
            assign prev_c = win_cost[j-1];
         end
         assign cell_en = (CMP_W'(j) < lim_eff) && (CMP_W'(j) < seen_ext);

         wmcp_cell u_cell (
            .clock       (clock),
            .shift_en    (finish),
            .enable      (cell_en),
            .cur_height  (height_ff),
            .prev_height (prev_h),
            .prev_cost   (prev_c),
            .height_q    (win_height[j]),
            .cost_q      (win_cost[j]),
            .cand_q      (leaf[j])
         );
      end
      for (genvar p = MAX_JUMP; p < LEAVES; p++) begin : g_pad
         assign leaf[p] = CAND_NONE;
      end
   endgenerate

   wmcp_min_tree #(
      .LEAVES (LEAVES)
   ) u_min_tree (
      .clock (clock),
      .leaf  (leaf),
      .root  (root)
   );

   // control next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      seen_in  = seen_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_CALC;
               cnt_in   = '0;
            end
         end
         ST_CALC: begin
            if (cnt_ff != CNT_DONE) begin
               cnt_in = cnt_ff + 1'b1;
            end
            if (finish) begin
               state_in = ST_IDLE;
               if (start_eff) begin
                  seen_in = SEEN_W'(1);
               end else if (seen_ff != SEEN_W'(MAX_JUMP)) begin
                  seen_in = seen_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         seen_ff       <= '0;
         jump_limit_ff <= JUMP_W'(1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         seen_ff  <= seen_in;
         if (csr_valid && csr_ready) begin
            jump_limit_ff <= csr_jump_limit;
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // request and result payload
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         height_ff <= req_height;
         start_ff  <= req_start_req;
      end
      if (finish) begin
         rsp_cost_ff <= new_cost;
         rsp_sat_ff  <= new_sat;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_cost      = rsp_cost_ff;
   assign rsp_saturated = rsp_sat_ff;

   // checks
   a_sat_is_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_sat_ff |-> rsp_cost_ff == COST_MAX)
      else $error("saturated result without maximum cost");

   a_seen_bound: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= SEEN_W'(MAX_JUMP))
      else $error("fill count beyond window depth");

   a_start_zero: assert property (@(posedge clock) disable iff (reset)
      finish && start_eff |=> rsp_cost_ff == '0 && !rsp_sat_ff && seen_ff == SEEN_W'(1))
      else $error("sequence start did not give zero cost");

   a_finish_settled: assert property (@(posedge clock) disable iff (reset)
      finish |-> $past(state_ff) == ST_CALC && !req_ready)
      else $error("result taken before tree settled");

endmodule

`default_nettype wire
